// ----- hw/rtl/sha1_message_digest_unit_assert.svh -----
// Assertion macros shared by the digest unit.
// Each macro checks one property on the rising clock edge, outside reset.
`ifndef SHA1_MESSAGE_DIGEST_UNIT_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_UNIT_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define SHA1MD_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("sha1md check failed");

// The condition holds in the cycle after the trigger.
`define SHA1MD_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("sha1md check failed");

`endif

// ----- hw/rtl/sha1md_pkg.sv -----
package sha1md_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ROUND_W  = 7;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned COUNT_W  = 61;
  localparam int unsigned NUM_WORDS = 5;

  localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
  localparam logic [7:0]         PAD_BYTE   = 8'h80;

  localparam logic [WORD_W-1:0] INIT_HASH [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Source of the byte that goes into the block.
  localparam logic [1:0] SEL_MSG  = 2'd0;
  localparam logic [1:0] SEL_PAD  = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;
  localparam logic [1:0] SEL_LEN  = 2'd3;

  typedef struct packed {
    logic       absorb;
    logic [1:0] byte_sel;
    logic       count_inc;
    logic       load_work;
    logic       round_step;
    logic       chain_add;
    logic       chain_init;
    logic [2:0] word_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             round_last;
  } dp_status_t;

  function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] t);
    logic [WORD_W-1:0] k;
    if (t < 7'd20) begin
      k = 32'h5A827999;
    end else if (t < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (t < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  function automatic logic [WORD_W-1:0] round_f(input logic [ROUND_W-1:0] t,
                                                input logic [WORD_W-1:0] b,
                                                input logic [WORD_W-1:0] c,
                                                input logic [WORD_W-1:0] d);
    logic [WORD_W-1:0] f;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

// ----- hw/rtl/sha1md_datapath.sv -----
module sha1md_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha1md_pkg::dp_cmd_t  cmd,
  input  logic [7:0]           msg_byte,
  output sha1md_pkg::dp_status_t status,
  output logic [31:0]          digest_word
);
  import sha1md_pkg::*;

  logic [WORD_W-1:0]  win_r [16];
  logic [WORD_W-1:0]  a_r, b_r, c_r, d_r, e_r;
  logic [ROUND_W-1:0] t_r;
  logic [WORD_W-1:0]  chain_r [NUM_WORDS];
  logic [COUNT_W-1:0] count_r;
  logic [POS_W-1:0]   pos_r;

  logic [7:0]        absorb_byte;
  logic [63:0]       bit_len;
  logic [WORD_W-1:0] sched_mix;
  logic [WORD_W-1:0] sched_word;
  logic [WORD_W-1:0] temp_word;

  assign bit_len    = {count_r, 3'b000};
  assign sched_mix  = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign sched_word = {sched_mix[30:0], sched_mix[31]};
  assign temp_word  = {a_r[26:0], a_r[31:27]} + round_f(t_r, b_r, c_r, d_r) + e_r
                      + win_r[0] + round_k(t_r);

  always_comb begin
    case (cmd.byte_sel)
      SEL_MSG:  absorb_byte = msg_byte;
      SEL_PAD:  absorb_byte = PAD_BYTE;
      SEL_ZERO: absorb_byte = 8'h00;
      SEL_LEN:  absorb_byte = bit_len[{~pos_r[2:0], 3'b000} +: 8];
      default:  absorb_byte = 8'h00;
    endcase
  end

  // Block window: bytes land in their big-endian lane, and during the rounds
  // the window slides so that entry 0 always holds the current schedule word.
  always_ff @(posedge clk) begin
    if (cmd.absorb) begin
      win_r[pos_r[5:2]][{~pos_r[1:0], 3'b000} +: 8] <= absorb_byte;
    end else if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= sched_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
      t_r <= '0;
    end else if (cmd.round_step) begin
      e_r <= d_r;
      d_r <= c_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      b_r <= a_r;
      a_r <= temp_word;
      t_r <= t_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.chain_init) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain_r[i] <= INIT_HASH[i];
      end
      count_r <= '0;
      pos_r   <= '0;
    end else begin
      if (cmd.chain_add) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
        chain_r[4] <= chain_r[4] + e_r;
      end
      if (cmd.count_inc) begin
        count_r <= count_r + 61'd1;
      end
      if (cmd.absorb) begin
        pos_r <= pos_r + 6'd1;
      end
    end
  end

  always_comb begin
    case (cmd.word_sel)
      3'd0:    digest_word = chain_r[0];
      3'd1:    digest_word = chain_r[1];
      3'd2:    digest_word = chain_r[2];
      3'd3:    digest_word = chain_r[3];
      3'd4:    digest_word = chain_r[4];
      default: digest_word = chain_r[4];
    endcase
  end

  assign status.pos        = pos_r;
  assign status.round_last = (t_r == LAST_ROUND);

endmodule

// ----- hw/rtl/sha1md_ctrl.sv -----
module sha1md_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_byte_present,
  input  logic                   in_end_of_message,
  output logic                   in_stall,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [2:0]             out_word_index,
  output logic                   out_last_word,
  input  sha1md_pkg::dp_status_t status,
  output sha1md_pkg::dp_cmd_t    cmd
);
  import sha1md_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PAD80  = 3'd1;
  localparam logic [2:0] ST_PADZ   = 3'd2;
  localparam logic [2:0] ST_PADLEN = 3'd3;
  localparam logic [2:0] ST_COMP   = 3'd4;
  localparam logic [2:0] ST_ADD    = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  localparam logic [POS_W-1:0] POS_FULL = 6'd63;
  localparam logic [POS_W-1:0] POS_LEN  = 6'd56;
  localparam logic [2:0]       LAST_IDX = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] ret_r, ret_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       block_full;

  assign block_full = (status.pos == POS_FULL);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.word_sel = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.absorb    = in_byte_present;
          cmd.count_inc = in_byte_present;
          cmd.byte_sel  = SEL_MSG;
          if (in_byte_present && block_full) begin
            cmd.load_work = 1'b1;
            state_nxt     = ST_COMP;
            ret_nxt       = in_end_of_message ? ST_PAD80 : ST_IDLE;
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD80;
          end
        end
      end
      ST_PAD80: begin
        cmd.absorb   = 1'b1;
        cmd.byte_sel = SEL_PAD;
        if (block_full) begin
          cmd.load_work = 1'b1;
          state_nxt     = ST_COMP;
          ret_nxt       = ST_PADZ;
        end else begin
          state_nxt = ST_PADZ;
        end
      end
      ST_PADZ: begin
        if (status.pos == POS_LEN) begin
          state_nxt = ST_PADLEN;
        end else begin
          cmd.absorb   = 1'b1;
          cmd.byte_sel = SEL_ZERO;
          if (block_full) begin
            cmd.load_work = 1'b1;
            state_nxt     = ST_COMP;
            ret_nxt       = ST_PADZ;
          end
        end
      end
      ST_PADLEN: begin
        cmd.absorb   = 1'b1;
        cmd.byte_sel = SEL_LEN;
        if (block_full) begin
          cmd.load_work = 1'b1;
          state_nxt     = ST_COMP;
          ret_nxt       = ST_OUT;
        end
      end
      ST_COMP: begin
        cmd.round_step = 1'b1;
        if (status.round_last) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.chain_add = 1'b1;
        state_nxt     = ret_r;
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (idx_r == LAST_IDX) begin
            cmd.chain_init = 1'b1;
            idx_nxt        = '0;
            state_nxt      = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = (state_r == ST_OUT);
  assign out_word_index = idx_r;
  assign out_last_word  = (idx_r == LAST_IDX);

endmodule

// ----- hw/rtl/sha1_message_digest_unit.sv -----
// Each accepted transfer with a byte absorbs it; a byte that completes a 64-byte block
// starts the 80 rounds and a chaining add, with input stalled, before the next transfer.
// End of message: the pad byte, zero fill and length bytes go in, each full block is
// compressed, then five output transfers follow. Reset (rst_n, synchronous, active
// low) loads the initial hash and clears the length and fill counters, as happens
// after each digest.
module sha1_message_digest_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_message_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha1md_pkg::*;

  // Commands flow from the controller into the datapath; the datapath reports the
  // fill position of the current block and whether the last round is under way.
  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller sequences message bytes, padding, the length field, the
  // compression rounds and the five digest word transfers.
  sha1md_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .in_stall          (in_stall),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word),
    .status            (status),
    .cmd               (cmd)
  );

  // The datapath holds the block window, working variables, chaining value and
  // the message length counter. The digest word is read straight from the chaining
  // registers, which do not move while a result transfer is stalled.
  sha1md_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .msg_byte    (in_message_byte),
    .status      (status),
    .digest_word (out_digest_word)
  );

`include "sha1_message_digest_unit_assert.svh"

  // An input transfer and a pending result never overlap in this design.
  `SHA1MD_ASSERT_SAME(a_no_input_while_output, in_valid && !in_stall, !out_valid)
  // While results are offered, no new input is taken.
  `SHA1MD_ASSERT_SAME(a_stall_during_output, out_valid, in_stall)
  // A word transfer that is not the last is followed by another offered word.
  `SHA1MD_ASSERT_NEXT(a_words_continue, out_valid && !out_stall && !out_last_word, out_valid)
  // After the final word the block is ready for a new message.
  `SHA1MD_ASSERT_NEXT(a_idle_after_digest, out_valid && !out_stall && out_last_word,
                      !out_valid && !in_stall)

endmodule

// ----- dv/sha1_message_digest_unit_test.sv -----
module sha1_message_digest_unit_test;

  // A stuck run is one with this many rising edges in a row where neither channel
  // completes a transfer. The slowest legitimate gap is a long output hold-off plus a
  // two-block finish (padding bytes and two compressions), well below this.
  localparam int STUCK_LIMIT   = 4000;
  // Quiet cycles allowed after the last digest word before the next phase starts.
  localparam int SETTLE_CYCLES = 20;
  // Length of the long output hold-off that backs the block up into its input.
  localparam int LONG_HOLD     = 300;
  localparam int REPORT_LIMIT  = 10;

  // SHA-1 round constants and initial chaining value.
  localparam logic [31:0] K_CHOOSE   = 32'h5A827999;
  localparam logic [31:0] K_PARITY_A = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
  localparam logic [31:0] K_PARITY_B = 32'hCA62C1D6;
  localparam logic [31:0] IV_0 = 32'h67452301;
  localparam logic [31:0] IV_1 = 32'hEFCDAB89;
  localparam logic [31:0] IV_2 = 32'h98BADCFE;
  localparam logic [31:0] IV_3 = 32'h10325476;
  localparam logic [31:0] IV_4 = 32'hC3D2E1F0;
  localparam logic [7:0]  PAD_MARK  = 8'h80;
  localparam logic [5:0]  LEN_FIELD_POS = 6'd56;
  localparam logic [2:0]  FINAL_WORD = 3'd4;

  // One digest word as it should appear on the result channel.
  typedef struct packed {
    logic [31:0] word_val;
    logic [2:0]  idx;
    logic        is_last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_message_byte = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  // Digest words still owed by the block, oldest first.
  digest_beat_t expected_words[$];
  digest_beat_t oldest_word;

  // Shadow of the hashing state: chaining value, block buffer, byte length, fill.
  logic [31:0] chain_words[5];
  logic [31:0] block_buf[16];
  logic [60:0] msg_bytes;
  logic [5:0]  fill_pos;

  int mismatch_count = 0;
  int stuck_cycles   = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_left      = 0;

  always #2 clk = ~clk;

  sha1_message_digest_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_message_byte   (in_message_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  // ---------------------------------------------------------------------------
  // Digest predictor. It tracks the same state the block keeps and, for every
  // input transfer, appends the digest words that transfer causes.
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void clear_hash_state();
    chain_words[0] = IV_0;
    chain_words[1] = IV_1;
    chain_words[2] = IV_2;
    chain_words[3] = IV_3;
    chain_words[4] = IV_4;
    msg_bytes = '0;
    fill_pos  = '0;
  endfunction

  // Runs the 80 rounds over the full block buffer and folds the result into the
  // chaining value.
  function automatic void compress_block();
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, sum;
    for (int t = 0; t < 16; t++) begin
      w[t] = block_buf[t];
    end
    for (int t = 16; t < 80; t++) begin
      w[t] = rotl(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
    end
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    e = chain_words[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K_CHOOSE;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K_PARITY_A;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJORITY;
      end else begin
        f = b ^ c ^ d;
        k = K_PARITY_B;
      end
      sum = rotl(a, 5) + f + e + w[t] + k;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = sum;
    end
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
    chain_words[4] += e;
  endfunction

  // Places one byte big-endian into the block buffer. The first byte of a word
  // clears the rest of it, so stale bytes from an earlier block never leak in.
  function automatic void absorb_byte(input logic [7:0] b);
    if (fill_pos[1:0] == 2'd0) begin
      block_buf[fill_pos[5:2]] = {b, 24'h000000};
    end else begin
      block_buf[fill_pos[5:2]][(3 - fill_pos[1:0]) * 8 +: 8] = b;
    end
    if (fill_pos == 6'd63) begin
      compress_block();
      fill_pos = '0;
    end else begin
      fill_pos = fill_pos + 6'd1;
    end
  endfunction

  // A byte is absorbed before any finish on the same transfer. On finish, the
  // pad marker, zero fill up to the length field and the 64-bit bit length go
  // in, then five digest words are owed and the state starts over. The byte
  // count is 61 bits wide, so the bit length naturally wraps modulo 2^64.
  function automatic void predict_digest(input logic [7:0] b, input logic present,
                                         input logic eom);
    logic [63:0]  bit_len;
    digest_beat_t beat;
    if (present) begin
      absorb_byte(b);
      msg_bytes = msg_bytes + 61'd1;
    end
    if (eom) begin
      bit_len = {msg_bytes, 3'b000};
      absorb_byte(PAD_MARK);
      while (fill_pos != LEN_FIELD_POS) begin
        absorb_byte(8'h00);
      end
      for (int i = 7; i >= 0; i--) begin
        absorb_byte(bit_len[8*i +: 8]);
      end
      for (int i = 0; i < 5; i++) begin
        beat.word_val = chain_words[i];
        beat.idx      = 3'(i);
        beat.is_last  = (3'(i) == FINAL_WORD);
        expected_words.push_back(beat);
      end
      clear_hash_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side. The receiver stalls at random, or for a counted stretch when a
  // test asks for a long hold-off. Stall changes on the falling edge only.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic note_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%s", msg);
    end
  endtask

  // Every output transfer is matched against the oldest owed digest word.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        note_error($sformatf("unexpected digest word: word=%h index=%0d last=%b",
                             out_digest_word, out_word_index, out_last_word));
      end else begin
        oldest_word = expected_words.pop_front();
        if (out_digest_word !== oldest_word.word_val ||
            out_word_index !== oldest_word.idx ||
            out_last_word !== oldest_word.is_last) begin
          note_error($sformatf({"digest mismatch: expected word=%h index=%0d last=%b,",
                                " got word=%h index=%0d last=%b"},
                               oldest_word.word_val, oldest_word.idx, oldest_word.is_last,
                               out_digest_word, out_word_index, out_last_word));
        end
      end
    end
  end

  // Watchdog: the run is declared hung once no transfer happens on either
  // channel for STUCK_LIMIT consecutive edges.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("sha1_message_digest_unit_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Every task here starts and ends just after a falling edge, so
  // inputs only ever change there. Valid stays high from one item to the next
  // unless the sender decides to idle, and a stalled payload is left alone.
  // ---------------------------------------------------------------------------

  task automatic send_item(input logic [7:0] b, input logic present, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_message_byte   = b;
    in_byte_present   = present;
    in_end_of_message = eom;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    // The transfer happened on this edge; the owed digest words follow from it.
    predict_digest(b, present, eom);
    if (present || eom) begin
      items_sent++;
    end
    @(negedge clk);
  endtask

  // Sends one message of len bytes with the odd empty item mixed in. The finish
  // either rides on the last byte or comes as a finish-only item.
  task automatic send_message(input int len, input bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) begin
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      end
      send_item(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1));
    end
    if (len == 0 || !end_on_byte) begin
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  // The sender stops and waits until every owed digest word has been seen.
  task automatic wait_for_digests();
    in_valid = 1'b0;
    while (expected_words.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Short hand-picked messages: the empty message, an empty item that must do
  // nothing, a byte carrying the finish, the classic three-letter message, and
  // the extreme byte values followed by a finish-only item.
  task automatic test_short_messages();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    send_item(8'($urandom_range(255)), 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'($urandom_range(255)), 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    wait_for_digests();
  endtask

  // The receiver holds off for a long counted stretch while the sender keeps
  // offering several short messages, so digest words pile up and the block has
  // to stall its input until the hold-off ends.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_left = LONG_HOLD;
    @(negedge clk);
    for (int m = 0; m < 4; m++) begin
      send_message(2, 1'b1);
    end
    wait_for_digests();
  endtask

  // Random messages. Most are short; about a quarter have 52 to 70 bytes, around
  // the length-field boundary at byte 56 or long enough to fill one whole block.
  task automatic test_random_messages(input int send_pct, input int recv_pct,
                                      input int n_items);
    int first;
    int len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if ($urandom_range(3) == 0) begin
        len = $urandom_range(70, 52);
      end else begin
        len = $urandom_range(10);
      end
      send_message(len, 1'($urandom_range(1)));
    end
    wait_for_digests();
  endtask

  initial begin
    clear_hash_state();
    // Reset is held low while the clock runs and released on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_short_messages();
    test_output_backpressure();
    test_random_messages(13, 68, 55);
    test_random_messages(68, 13, 55);
    test_random_messages(0, 0, 55);

    mismatch_count += expected_words.size();
    if (mismatch_count == 0) begin
      $display("sha1_message_digest_unit_test: clean");
    end else begin
      $display("sha1_message_digest_unit_test: errors");
    end
    $finish;
  end

endmodule
